FILE: hdl/bhbs_pkg.sv
// ----------------------------------------------------------------------------
// bhbs_pkg
// Shared constants, types and helpers of the bucket selector.
// ----------------------------------------------------------------------------
`default_nettype none

package bhbs_pkg;

    localparam logic [63:0] MIX_MULT    = 64'h27BB2EE687B0B0FD;
    localparam int          RETRIES     = 4;
    localparam logic [16:0] MAX_BUCKETS = 17'h10000;
    localparam int          MIX_STAGES  = 6;

    localparam int CNT_W    = 17;
    localparam int BUCKET_W = 16;
    localparam int HASH_W   = 64;

    // word index of the register file
    localparam logic REG_BUCKET_COUNT = 1'b0;

    typedef struct packed {
        logic [CNT_W-1:0]    n;
        logic [BUCKET_W-1:0] encl;
        logic [BUCKET_W-1:0] minor;
        logic                trivial;
    } bhbs_cfg_t;

    typedef struct packed {
        logic [HASH_W-1:0]   h;
        logic [BUCKET_W-1:0] fall;
        logic [BUCKET_W-1:0] res;
        logic                done;
    } bhbs_ctx_t;

    // all bits below the highest set bit are set
    function automatic logic [BUCKET_W-1:0] smear16(input logic [BUCKET_W-1:0] v);
        logic [BUCKET_W-1:0] s;
        s = v;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        return s;
    endfunction

    function automatic logic [BUCKET_W-1:0] top_bit16(input logic [BUCKET_W-1:0] v);
        logic [BUCKET_W-1:0] s;
        s = smear16(v);
        return s & ~(s >> 1);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bhbs_mix.sv
// ----------------------------------------------------------------------------
// bhbs_mix
// Six-stage rehash datapath: m = ((C*v+1)^2 * seed) >> 32, modulo 2^64.
// ----------------------------------------------------------------------------
`default_nettype none

module bhbs_mix
    import bhbs_pkg::*;
(
    input  logic              clk,
    input  logic              ce,
    input  logic [HASH_W-1:0] v,
    input  logic [15:0]       seed,
    output logic [31:0]       m
);

    localparam logic [31:0] C_LO = MIX_MULT[31:0];
    localparam logic [31:0] C_HI = MIX_MULT[63:32];

    logic [63:0] p0_reg, p0_next;
    logic [31:0] p1_reg, p1_next;
    logic [31:0] p2_reg, p2_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] q0_reg, q0_next;
    logic [31:0] q1_reg, q1_next;
    logic [63:0] hh_reg, hh_next;
    logic [47:0] r0_full;
    logic [15:0] r0_reg, r0_next;
    logic [31:0] r1_reg, r1_next;
    logic [31:0] m_reg, m_next;
    logic [31:0] cross_sum;
    logic [15:0] seed1_reg, seed2_reg, seed3_reg, seed4_reg;

    always_comb
    begin
        p0_next = {32'b0, C_LO} * {32'b0, v[31:0]};
        p1_next = C_LO * v[63:32];
        p2_next = C_HI * v[31:0];

        cross_sum = p1_reg + p2_reg;
        h_next    = p0_reg + {cross_sum, 32'b0} + 64'd1;

        q0_next = {32'b0, h_reg[31:0]} * {32'b0, h_reg[31:0]};
        q1_next = h_reg[31:0] * h_reg[63:32];

        // cross term appears twice
        hh_next = q0_reg + {q1_reg[30:0], 33'b0};

        r0_full = {16'b0, hh_reg[31:0]} * {32'b0, seed4_reg};
        r0_next = r0_full[47:32];
        r1_next = hh_reg[63:32] * {16'b0, seed4_reg};

        m_next = r1_reg + {16'b0, r0_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            seed1_reg <= seed;
            h_reg     <= h_next;
            seed2_reg <= seed1_reg;
            q0_reg    <= q0_next;
            q1_reg    <= q1_next;
            seed3_reg <= seed2_reg;
            hh_reg    <= hh_next;
            seed4_reg <= seed3_reg;
            r0_reg    <= r0_next;
            r1_reg    <= r1_next;
            m_reg     <= m_next;
        end
    end

    assign m = m_reg;

endmodule

`default_nettype wire

FILE: hdl/bhbs_front.sv
// ----------------------------------------------------------------------------
// bhbs_front
// Input stage, both level relocations and the first range check.
// ----------------------------------------------------------------------------
`default_nettype none

module bhbs_front
    import bhbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  bhbs_cfg_t         cfg,
    input  logic              in_valid,
    input  logic [HASH_W-1:0] in_hash,
    output logic              out_valid,
    output bhbs_ctx_t         out_ctx
);

    localparam int LAST = MIX_STAGES - 1;

    logic                valid0_reg;
    logic [HASH_W-1:0]   hash0_reg;
    logic [BUCKET_W-1:0] b0a, b0b, filt_a, filt_b;
    logic [31:0]         ma, mb;

    logic                valid_pipe_reg [MIX_STAGES];
    logic [HASH_W-1:0]   hash_pipe_reg  [MIX_STAGES];
    logic [BUCKET_W-1:0] ba_pipe_reg    [MIX_STAGES];
    logic [BUCKET_W-1:0] bb_pipe_reg    [MIX_STAGES];

    logic [BUCKET_W-1:0] ba_t, bb_t, top_a, top_b, reloc_a, reloc_b;
    logic                out_valid_reg;
    bhbs_ctx_t           out_ctx_reg, out_ctx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            hash0_reg <= in_hash;
        end
    end

    always_comb
    begin
        b0a    = hash0_reg[BUCKET_W-1:0] & cfg.encl;
        b0b    = hash0_reg[BUCKET_W-1:0] & cfg.minor;
        filt_a = top_bit16(b0a) - 16'd1;
        filt_b = top_bit16(b0b) - 16'd1;
    end

    bhbs_mix u_mix_a
    (
        .clk  (clk),
        .ce   (ce),
        .v    (hash0_reg),
        .seed (filt_a),
        .m    (ma)
    );

    bhbs_mix u_mix_b
    (
        .clk  (clk),
        .ce   (ce),
        .v    (hash0_reg),
        .seed (filt_b),
        .m    (mb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MIX_STAGES; i++)
            begin
                valid_pipe_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            valid_pipe_reg[0] <= valid0_reg;
            for (int i = 1; i < MIX_STAGES; i++)
            begin
                valid_pipe_reg[i] <= valid_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            hash_pipe_reg[0] <= hash0_reg;
            ba_pipe_reg[0]   <= b0a;
            bb_pipe_reg[0]   <= b0b;
            for (int i = 1; i < MIX_STAGES; i++)
            begin
                hash_pipe_reg[i] <= hash_pipe_reg[i-1];
                ba_pipe_reg[i]   <= ba_pipe_reg[i-1];
                bb_pipe_reg[i]   <= bb_pipe_reg[i-1];
            end
        end
    end

    always_comb
    begin
        ba_t  = ba_pipe_reg[LAST];
        bb_t  = bb_pipe_reg[LAST];
        top_a = top_bit16(ba_t);
        top_b = top_bit16(bb_t);

        // buckets 0 and 1 stay where they are
        reloc_a = (ba_t < 16'd2) ? ba_t : (top_a | (ma[15:0] & (top_a - 16'd1)));
        reloc_b = (bb_t < 16'd2) ? bb_t : (top_b | (mb[15:0] & (top_b - 16'd1)));

        out_ctx_next.h    = hash_pipe_reg[LAST];
        out_ctx_next.fall = reloc_b;
        out_ctx_next.done = cfg.trivial || ({1'b0, reloc_a} < cfg.n);
        out_ctx_next.res  = cfg.trivial ? '0 : reloc_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= valid_pipe_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_ctx_reg <= out_ctx_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ctx   = out_ctx_reg;

endmodule

`default_nettype wire

FILE: hdl/bhbs_round.sv
// ----------------------------------------------------------------------------
// bhbs_round
// One rehash retry under the enclosing mask, with its early-exit checks.
// ----------------------------------------------------------------------------
`default_nettype none

module bhbs_round
    import bhbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      ce,
    input  bhbs_cfg_t cfg,
    input  logic      in_valid,
    input  bhbs_ctx_t in_ctx,
    output logic      out_valid,
    output bhbs_ctx_t out_ctx
);

    localparam int LAST = MIX_STAGES - 1;

    logic [31:0]         m;
    logic                valid_pipe_reg [MIX_STAGES];
    bhbs_ctx_t           ctx_pipe_reg   [MIX_STAGES];
    bhbs_ctx_t           tail;
    logic [BUCKET_W-1:0] b;
    logic                out_valid_reg;
    bhbs_ctx_t           out_ctx_reg, out_ctx_next;

    bhbs_mix u_mix
    (
        .clk  (clk),
        .ce   (ce),
        .v    (in_ctx.h),
        .seed (cfg.encl),
        .m    (m)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MIX_STAGES; i++)
            begin
                valid_pipe_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            valid_pipe_reg[0] <= in_valid;
            for (int i = 1; i < MIX_STAGES; i++)
            begin
                valid_pipe_reg[i] <= valid_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ctx_pipe_reg[0] <= in_ctx;
            for (int i = 1; i < MIX_STAGES; i++)
            begin
                ctx_pipe_reg[i] <= ctx_pipe_reg[i-1];
            end
        end
    end

    always_comb
    begin
        tail           = ctx_pipe_reg[LAST];
        b              = m[BUCKET_W-1:0] & cfg.encl;
        out_ctx_next   = tail;
        out_ctx_next.h = {32'b0, m};
        if (!tail.done)
        begin
            // landing in the minor tree ends the retries
            if (b <= cfg.minor)
            begin
                out_ctx_next.done = 1'b1;
                out_ctx_next.res  = tail.fall;
            end
            else if ({1'b0, b} < cfg.n)
            begin
                out_ctx_next.done = 1'b1;
                out_ctx_next.res  = b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= valid_pipe_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_ctx_reg <= out_ctx_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ctx   = out_ctx_reg;

endmodule

`default_nettype wire

FILE: hdl/binomial_hash_bucket_select.sv
// ----------------------------------------------------------------------------
// binomial_hash_bucket_select
// Consistent-hash bucket selector: maps a 64-bit key hash to a bucket
// below the configured bucket count, or bucket 0 when the count is 0.
// ----------------------------------------------------------------------------
//  channel   dir  word                  fields (low bit up)
//  s_axis    in   64-bit key hash       key_hash[63:0]
//  m_axis    out  16-bit bucket         bucket[15:0]
//  apb       in   bucket_count @ 0x0    bucket_count[16:0]
//
//  One word per cycle while m_axis is not stalled. Path: entry register,
//  6-stage rehash multiplier chain plus a check stage for the relocations,
//  the same for each retry, then the output reg.
//  Reset clears all valid bits and sets bucket_count to 1.
//  A stalled m_axis is absorbed by a one-word skid; once it fills,
//  s_axis_tready drops and the whole pipeline holds.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_hash_bucket_select
    import bhbs_pkg::*;
#(
    parameter int RETRIES = bhbs_pkg::RETRIES
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key_hash[63:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // bucket[15:0]

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                wr_en;
    logic [CNT_W-1:0]    n_sat, nm1;
    bhbs_cfg_t           cfg;

    logic                ce;
    logic [RETRIES:0]    valid_chain;
    bhbs_ctx_t           ctx_chain [RETRIES+1];
    logic [BUCKET_W-1:0] up_data;
    logic                up_valid;

    logic                out_valid_reg, out_valid_next;
    logic [BUCKET_W-1:0] out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [BUCKET_W-1:0] skid_data_reg, skid_data_next;

    // register file
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        count_next = count_reg;
        prdata     = '0;
        unique case (paddr[2])
            REG_BUCKET_COUNT:
            begin
                if (wr_en)
                begin
                    count_next = pwdata[CNT_W-1:0];
                end
                prdata = {15'b0, count_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 17'd1;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        n_sat       = (count_reg > MAX_BUCKETS) ? MAX_BUCKETS : count_reg;
        nm1         = n_sat - 17'd1;
        cfg.n       = n_sat;
        cfg.trivial = (n_sat < 17'd2);
        cfg.encl    = smear16(nm1[BUCKET_W-1:0]);
        cfg.minor   = cfg.encl >> 1;
    end

    // pipeline
    assign ce            = !skid_valid_reg;
    assign s_axis_tready = ce;

    bhbs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_hash   (s_axis_tdata),
        .out_valid (valid_chain[0]),
        .out_ctx   (ctx_chain[0])
    );

    for (genvar gi = 0; gi < RETRIES; gi++)
    begin : g_round
        bhbs_round u_round
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .cfg       (cfg),
            .in_valid  (valid_chain[gi]),
            .in_ctx    (ctx_chain[gi]),
            .out_valid (valid_chain[gi+1]),
            .out_ctx   (ctx_chain[gi+1])
        );
    end

    assign up_valid = valid_chain[RETRIES];
    assign up_data  = ctx_chain[RETRIES].done ? ctx_chain[RETRIES].res
                                              : ctx_chain[RETRIES].fall;

    // output register with skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (ce && up_valid)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_next = 1'b1;
                out_data_next  = up_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = up_data;
            end
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: hdl/bhbs_checker.sv
// ----------------------------------------------------------------------------
// bhbs_checker
// Port-level checks of the bucket selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bhbs_checker
    import bhbs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    logic [CNT_W-1:0] shadow_reg;
    logic [CNT_W-1:0] shadow_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg <= 17'd1;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_BUCKET_COUNT)
        begin
            shadow_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign shadow_sat = (shadow_reg > MAX_BUCKETS) ? MAX_BUCKETS : shadow_reg;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (shadow_sat < 17'd2 && m_axis_tdata == 16'd0) ||
                          (shadow_sat >= 17'd2 && {1'b0, m_axis_tdata} < shadow_sat))
        else $error("bucket not below bucket_count");

    a_skid: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input held off with no word on the output");

    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && paddr[2] == REG_BUCKET_COUNT |-> prdata == {15'b0, shadow_reg})
        else $error("bucket_count readback mismatch");

endmodule

bind binomial_hash_bucket_select bhbs_checker u_bhbs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the consistent-hash bucket selector. Key hashes
// go in on the input stream and bucket_count is set over APB between
// phases, with a read back after each write. A scoreboard predicts each
// bucket and compares it with the output stream in order. Both sides idle
// at random, and the output side also holds off long enough to fill the
// pipeline.
// ----------------------------------------------------------------------------

import bhbs_pkg::*;

class bucket_scoreboard;
    logic [15:0] pending_buckets[$];
    int          errors;
    int          checked;

    static function logic [63:0] mix64(input logic [63:0] v, input logic [63:0] seed);
        logic [63:0] h;
        logic [63:0] p;
        h = bhbs_pkg::MIX_MULT * v + 64'd1;
        p = h * h * seed;
        return p >> 32;
    endfunction

    static function logic [63:0] top_bit64(input logic [63:0] v);
        logic [63:0] b;
        b = 64'd0;
        for (int k = 0; k < 64; k++)
        begin
            if (v[k])
                b = 64'd1 << k;
        end
        return b;
    endfunction

    static function logic [63:0] relocate(input logic [63:0] b, input logic [63:0] hash);
        logic [63:0] base;
        logic [63:0] filt;
        if (b < 64'd2)
            return b;
        base = top_bit64(b);
        filt = base - 64'd1;
        return base + (mix64(hash, filt) & filt);
    endfunction

    static function logic [15:0] predict_bucket(input logic [63:0] hash,
                                                input logic [16:0] cnt);
        logic [63:0] n;
        logic [63:0] top;
        logic [63:0] encl;
        logic [63:0] minor;
        logic [63:0] b;
        logic [63:0] h;
        n = {47'd0, cnt};
        if (n > 64'd65536)
            n = 64'd65536;
        if (n < 64'd2)
            return 16'd0;
        top = top_bit64(n);
        if (n > top)
            top = top << 1;
        encl  = top - 64'd1;
        minor = encl >> 1;
        b = relocate(hash & encl, hash);
        if (b < n)
            return b[15:0];
        h = hash;
        for (int i = 0; i < RETRIES; i++)
        begin
            h = mix64(h, encl);
            b = h & encl;
            if (b <= minor)
                break;
            if (b < n)
                return b[15:0];
        end
        b = relocate(hash & minor, hash);
        return b[15:0];
    endfunction

    task report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function void note(input logic [63:0] hash, input logic [16:0] cnt);
        pending_buckets.push_back(predict_bucket(hash, cnt));
    endfunction

    task check(input logic [15:0] got);
        logic [15:0] want;
        checked++;
        if (pending_buckets.size() == 0)
            report($sformatf("bucket %0d with no word outstanding", got));
        else
        begin
            want = pending_buckets.pop_front();
            if (got !== want)
                report($sformatf("bucket %0d, predicted %0d", got, want));
        end
    endtask
endclass

module tb_top;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          PHASES         = 13;
    localparam int          PHASE_WORDS    = 150;
    localparam logic [2:0]  COUNT_ADDR     = {1'b0, REG_BUCKET_COUNT, 2'b00};

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;    // key_hash[63:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // bucket[15:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bucket_scoreboard sb = new;

    logic [16:0] bucket_count_q;
    bit          tx_idle_en;
    bit          rx_idle_en;
    int          rx_hold_len;
    int          words_sent;
    int          cfg_writes;

    binomial_hash_bucket_select DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task send_key(input logic [63:0] hash);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= hash;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note(hash, bucket_count_q);
        words_sent++;
    endtask

    task drain;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_buckets.size() != 0)
            @(posedge clk);
    endtask

    // write then read back; the stored value is the low 17 bits
    task set_bucket_count(input logic [16:0] cnt, input logic [14:0] junk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= {junk, cnt};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        bucket_count_q = cnt;
        cfg_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {15'd0, cnt})
            sb.report($sformatf("bucket_count reads %0h, wrote %0h", prdata, cnt));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: k[15:0] = 16'hFFFF;
            1: k = 64'd1 << $urandom_range(0, 63);
            2: k[15:0] = 16'($urandom_range(0, 7));
            default: ;
        endcase
        return k;
    endfunction

    // output side: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check(m_axis_tdata);
            if (rx_hold_len > 0)
            begin
                stall_left  = rx_hold_len;
                rx_hold_len = 0;
            end
            else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 6);
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", quiet);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [63:0] dir_keys [4];
        logic [16:0] dir_counts [5];
        logic [16:0] cnt;
        int          sel;

        dir_keys[0] = 64'd0;
        dir_keys[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        dir_keys[2] = 64'h8000_0000_0000_0001;
        dir_keys[3] = 64'h5555_5555_AAAA_AAAA;
        dir_counts[0] = 17'd0;
        dir_counts[1] = 17'd3;
        dir_counts[2] = 17'd65535;
        dir_counts[3] = 17'd65536;
        dir_counts[4] = 17'h1FFFF;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 64'd0;
        m_axis_tready  = 1'b1;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 3'd0;
        pwdata         = 32'd0;
        bucket_count_q = 17'd1;
        tx_idle_en     = 1'b0;
        rx_idle_en     = 1'b0;
        rx_hold_len    = 0;
        words_sent     = 0;
        cfg_writes     = 0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset count first, then empty, tiny, largest and oversize counts
        for (int k = 0; k < 4; k++)
            send_key(dir_keys[k]);
        drain();
        for (int c = 0; c < 5; c++)
        begin
            set_bucket_count(dir_counts[c], 15'd0);
            for (int k = 0; k < 4; k++)
                send_key(dir_keys[k]);
            drain();
        end

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: cnt = 17'd2;
                1: cnt = 17'd5;
                2: cnt = 17'd65536;
                3: cnt = 17'd65537;
                4: cnt = 17'd1;
                default:
                begin
                    sel = $urandom_range(0, 3);
                    if (sel == 0)
                        cnt = 17'($urandom_range(2, 64));
                    else if (sel == 1)
                        cnt = 17'($urandom_range(1, 65536));
                    else if (sel == 2)
                        cnt = 17'((17'd1 << $urandom_range(1, 16))
                                  + $urandom_range(0, 2) - 1);
                    else
                        cnt = 17'($urandom_range(0, 131071));
                end
            endcase
            if (p >= PHASES - 2)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            set_bucket_count(cnt, 15'($urandom_range(0, 32767)));
            if (p == 6)
            begin
                tx_idle_en  = 1'b0;
                rx_hold_len = 300;
            end
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                send_key(random_key());
                if (p == 8 && i == PHASE_WORDS / 2)
                    drain();
            end
            if (p == 6)
                tx_idle_en = 1'b1;
            drain();
        end

        repeat (50) @(posedge clk);
        if (sb.pending_buckets.size() != 0)
            sb.report($sformatf("%0d buckets never arrived", sb.pending_buckets.size()));

        $display("run covered %0d key hashes under %0d bucket_count writes",
                 words_sent, cfg_writes);
        $display("%0d buckets checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
